@@ hdl/pileup_locus_statistics_core_macros.svh @@
// assertion macros for the pileup locus statistics core
// no dependencies; included by the top level only
`ifndef PILEUP_LOCUS_STATISTICS_CORE_MACROS_SVH
`define PILEUP_LOCUS_STATISTICS_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/plc_pkg.sv @@
// shared types and constants for the pileup locus statistics core
// no dependencies
`timescale 1ns / 1ps

package plc_pkg;

  // fixed field widths
  localparam int unsigned POS_W      = 32;
  localparam int unsigned DEPTH_W    = 16;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // parameter defaults
  localparam int unsigned DEF_COUNT_BITS = 16;
  localparam int unsigned DEF_TALLY_BITS = 32;

  // register reset values
  localparam logic [DEPTH_W-1:0] RST_MIN_ALLELIC = 16'd12;
  localparam logic [DEPTH_W-1:0] RST_MIN_FLANK   = 16'd10;

  // one quotient bit per step, Q1.16 fraction up to one
  localparam int unsigned DIV_STEPS = FRAC_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FEATURE_START   = 3'd0,
    CFG_FEATURE_END     = 3'd1,
    CFG_USE_REFERENCE   = 3'd2,
    CFG_MIN_ALLELIC_DEP = 3'd3,
    CFG_MIN_FLANK_DEP   = 3'd4
  } plc_cfg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic classify;
    logic tally;
    logic div_init;
    logic div_step;
    logic load;
  } plc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;
    logic out_free;
  } plc_sts_t;

endpackage

@@ hdl/plc_div.sv @@
// restoring divider giving floor(dividend * 2^16 / divisor), dividend <= divisor
// depends on plc_pkg
`timescale 1ns / 1ps

module plc_div #(
  parameter int unsigned TALLY_BITS = plc_pkg::DEF_TALLY_BITS
) (
  input  logic                         clk_i,
  input  logic                         init_i,
  input  logic                         step_i,
  input  logic [TALLY_BITS-1:0]        dividend_i,
  input  logic [TALLY_BITS-1:0]        divisor_i,
  output logic [plc_pkg::FRAC_W-1:0]   quot_o
);
  import plc_pkg::*;

  logic [TALLY_BITS-1:0] rem_q, rem_d;
  logic [FRAC_W-1:0]     quot_q;
  logic [TALLY_BITS:0]   cand;
  logic                  ge;

  // first step tests the integer bit, later steps shift the remainder
  always_comb begin
    cand  = init_i ? {1'b0, dividend_i} : {rem_q, 1'b0};
    ge    = cand >= {1'b0, divisor_i};
    rem_d = ge ? TALLY_BITS'(cand - {1'b0, divisor_i}) : TALLY_BITS'(cand);
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      rem_q  <= rem_d;
      quot_q <= {quot_q[FRAC_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;

endmodule

@@ hdl/plc_dp.sv @@
// datapath: config registers, locus classification, tallies, divider, result register
// depends on plc_pkg and plc_div
`timescale 1ns / 1ps

module plc_dp #(
  parameter int unsigned COUNT_BITS = plc_pkg::DEF_COUNT_BITS,
  parameter int unsigned TALLY_BITS = plc_pkg::DEF_TALLY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  plc_pkg::plc_cmd_t                cmd_i,
  output plc_pkg::plc_sts_t                sts_o,
  input  logic                             cfg_we_i,
  input  logic [plc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic [plc_pkg::POS_W-1:0]        position_i,
  input  logic [plc_pkg::DEPTH_W-1:0]      depth_i,
  input  logic [COUNT_BITS-1:0]            count_a_i,
  input  logic [COUNT_BITS-1:0]            count_c_i,
  input  logic [COUNT_BITS-1:0]            count_g_i,
  input  logic [COUNT_BITS-1:0]            count_t_i,
  input  logic [COUNT_BITS-1:0]            count_nonref_i,
  input  logic                             last_locus_i,
  input  logic                             out_stall_i,
  output logic                             out_valid_o,
  output logic [plc_pkg::OUT_W-1:0]        multiallelic_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        unbalanced_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        flank_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        nonref_flank_loci_o,
  output logic [plc_pkg::FRAC_W-1:0]       nonref_fraction_o,
  output logic                             no_flank_loci_o
);
  import plc_pkg::*;

  // widths of the cross-multiplied compares
  localparam int unsigned MW = ((COUNT_BITS > DEPTH_W) ? COUNT_BITS : DEPTH_W) + 3;
  localparam int unsigned NW = ((COUNT_BITS + 8 > DEPTH_W) ? COUNT_BITS + 8 : DEPTH_W);
  localparam int unsigned UW = COUNT_BITS + 4;

  // config registers
  logic [POS_W-1:0]   feat_start_q, feat_end_q;
  logic               use_ref_q;
  logic [DEPTH_W-1:0] min_allelic_q, min_flank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      feat_start_q  <= '0;
      feat_end_q    <= '0;
      use_ref_q     <= 1'b0;
      min_allelic_q <= RST_MIN_ALLELIC;
      min_flank_q   <= RST_MIN_FLANK;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_FEATURE_START:   feat_start_q  <= POS_W'(cfg_data_i);
        CFG_FEATURE_END:     feat_end_q    <= POS_W'(cfg_data_i);
        CFG_USE_REFERENCE:   use_ref_q     <= cfg_data_i[0];
        CFG_MIN_ALLELIC_DEP: min_allelic_q <= cfg_data_i[DEPTH_W-1:0];
        CFG_MIN_FLANK_DEP:   min_flank_q   <= cfg_data_i[DEPTH_W-1:0];
        default: ;
      endcase
    end
  end

  // input item registers
  logic [POS_W-1:0]      pos_q;
  logic [DEPTH_W-1:0]    depth_q;
  logic [COUNT_BITS-1:0] base_q [4];
  logic [COUNT_BITS-1:0] nonref_q;
  logic                  last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      pos_q     <= position_i;
      depth_q   <= depth_i;
      base_q[0] <= count_a_i;
      base_q[1] <= count_c_i;
      base_q[2] <= count_g_i;
      base_q[3] <= count_t_i;
      nonref_q  <= count_nonref_i;
      last_q    <= last_locus_i;
    end
  end

  // classification of the held locus
  logic                  in_feature, allelic_ok, all_below, flank_ok, nonref_ok;
  logic [COUNT_BITS-1:0] mx, second;
  logic [1:0]            imax;

  always_comb begin
    in_feature = (pos_q > feat_start_q) && (pos_q < feat_end_q);
    allelic_ok = (depth_q >= min_allelic_q) && (depth_q != '0);
    all_below  = 1'b1;
    for (int k = 0; k < 4; k++) begin
      if (MW'(base_q[k]) * MW'(5) >= MW'(depth_q) * MW'(4)) begin
        all_below = 1'b0;
      end
    end
    // first maximum wins a tie
    mx   = base_q[0];
    imax = 2'd0;
    for (int k = 1; k < 4; k++) begin
      if (base_q[k] > mx) begin
        mx   = base_q[k];
        imax = 2'(k);
      end
    end
    second = '0;
    for (int k = 0; k < 4; k++) begin
      if ((2'(k) != imax) && (base_q[k] > second)) begin
        second = base_q[k];
      end
    end
    flank_ok  = !in_feature && (depth_q >= min_flank_q);
    nonref_ok = use_ref_q && (depth_q != '0) &&
                (NW'(nonref_q) * NW'(200) >= NW'(depth_q));
  end

  logic                  multi_q, flank_q, nonref_hit_q;
  logic [COUNT_BITS-1:0] mx_q, second_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.classify) begin
      multi_q      <= in_feature && allelic_ok && all_below;
      flank_q      <= flank_ok;
      nonref_hit_q <= flank_ok && nonref_ok;
      mx_q         <= mx;
      second_q     <= second;
    end
  end

  // minor share strictly between 0.2 and 0.3
  logic [UW-1:0] share_sum;
  logic          unbal;

  always_comb begin
    share_sum = UW'(mx_q) + UW'(second_q);
    unbal = (share_sum != '0) &&
            (UW'(second_q) * UW'(5) > share_sum) &&
            (UW'(second_q) * UW'(10) < share_sum * UW'(3));
  end

  // saturating tallies, cleared when the result is loaded
  logic [TALLY_BITS-1:0] multi_tally_q, unbal_tally_q, flank_tally_q, nonref_tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multi_tally_q  <= '0;
      unbal_tally_q  <= '0;
      flank_tally_q  <= '0;
      nonref_tally_q <= '0;
    end else if (cmd_i.load) begin
      multi_tally_q  <= '0;
      unbal_tally_q  <= '0;
      flank_tally_q  <= '0;
      nonref_tally_q <= '0;
    end else if (cmd_i.tally) begin
      if (multi_q && (multi_tally_q != '1)) begin
        multi_tally_q <= multi_tally_q + 1'b1;
      end
      if (multi_q && unbal && (unbal_tally_q != '1)) begin
        unbal_tally_q <= unbal_tally_q + 1'b1;
      end
      if (flank_q && (flank_tally_q != '1)) begin
        flank_tally_q <= flank_tally_q + 1'b1;
      end
      if (nonref_hit_q && (nonref_tally_q != '1)) begin
        nonref_tally_q <= nonref_tally_q + 1'b1;
      end
    end
  end

  // flank non-reference fraction
  logic [FRAC_W-1:0] quot;

  plc_div #(
    .TALLY_BITS(TALLY_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .init_i     (cmd_i.div_init),
    .step_i     (cmd_i.div_step),
    .dividend_i (nonref_tally_q),
    .divisor_i  (flank_tally_q),
    .quot_o     (quot)
  );

  // result register
  logic              out_valid_q;
  logic [OUT_W-1:0]  multi_out_q, unbal_out_q, flank_out_q, nonref_out_q;
  logic [FRAC_W-1:0] frac_out_q;
  logic              none_out_q;
  logic              no_flank;

  assign no_flank = (flank_tally_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      multi_out_q  <= OUT_W'(multi_tally_q);
      unbal_out_q  <= OUT_W'(unbal_tally_q);
      flank_out_q  <= OUT_W'(flank_tally_q);
      nonref_out_q <= OUT_W'(nonref_tally_q);
      frac_out_q   <= (no_flank || !use_ref_q) ? '0 : quot;
      none_out_q   <= no_flank;
    end
  end

  assign sts_o.last          = last_q;
  assign sts_o.out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o         = out_valid_q;
  assign multiallelic_loci_o = multi_out_q;
  assign unbalanced_loci_o   = unbal_out_q;
  assign flank_loci_o        = flank_out_q;
  assign nonref_flank_loci_o = nonref_out_q;
  assign nonref_fraction_o   = frac_out_q;
  assign no_flank_loci_o     = none_out_q;

endmodule

@@ hdl/plc_ctrl.sv @@
// controller: sequences capture, classify, tally, divide and result load
// depends on plc_pkg
`timescale 1ns / 1ps

module plc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  plc_pkg::plc_sts_t  sts_i,
  output plc_pkg::plc_cmd_t  cmd_o
);
  import plc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASS,
    S_TALLY,
    S_DIV,
    S_LOAD
  } state_e;

  state_e               state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                 in_stall_q, in_stall_d;

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_CLASS;
        end
      end
      S_CLASS: state_d = S_TALLY;
      S_TALLY: begin
        cnt_d   = '0;
        state_d = sts_i.last ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_LOAD: begin
        if (sts_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    in_stall_d = (state_d != S_IDLE);
  end

  // state and registered stall
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      in_stall_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      in_stall_q <= in_stall_d;
    end
  end

  // command decode
  always_comb begin
    cmd_o.capture  = (state_q == S_IDLE) && in_valid_i;
    cmd_o.classify = (state_q == S_CLASS);
    cmd_o.tally    = (state_q == S_TALLY);
    cmd_o.div_init = (state_q == S_DIV) && (cnt_q == '0);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.load     = (state_q == S_LOAD) && sts_i.out_free;
  end

  assign in_stall_o = in_stall_q;

endmodule

@@ hdl/pileup_locus_statistics_core.sv @@
// channel   direction  handshake                 payload
// in        input      in_valid_i / in_stall_o   position, depth, base counts, last_locus
// out       output     out_valid_o / out_stall_i four tallies, fraction, no_flank_loci
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// an item that is not the last locus goes through capture, classify and tally update
// the last locus then steps the bit-serial divider and loads the result
// the result register frees the input side; a new result waits only if the old one is held
// reset is asynchronous, active low; tallies clear to zero, config registers take their defaults
// cfg_ready_o is always high
// top level of the pileup locus statistics core; depends on plc_pkg, plc_ctrl, plc_dp and the macros header
`timescale 1ns / 1ps
`include "pileup_locus_statistics_core_macros.svh"

module pileup_locus_statistics_core #(
  parameter int unsigned COUNT_BITS = plc_pkg::DEF_COUNT_BITS,
  parameter int unsigned TALLY_BITS = plc_pkg::DEF_TALLY_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [plc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [plc_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [plc_pkg::POS_W-1:0]        position_i,
  input  logic [plc_pkg::DEPTH_W-1:0]      depth_i,
  input  logic [COUNT_BITS-1:0]            count_a_i,
  input  logic [COUNT_BITS-1:0]            count_c_i,
  input  logic [COUNT_BITS-1:0]            count_g_i,
  input  logic [COUNT_BITS-1:0]            count_t_i,
  input  logic [COUNT_BITS-1:0]            count_nonref_i,
  input  logic                             last_locus_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [plc_pkg::OUT_W-1:0]        multiallelic_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        unbalanced_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        flank_loci_o,
  output logic [plc_pkg::OUT_W-1:0]        nonref_flank_loci_o,
  output logic [plc_pkg::FRAC_W-1:0]       nonref_fraction_o,
  output logic                             no_flank_loci_o
);
  import plc_pkg::*;

  plc_cmd_t cmd;
  plc_sts_t sts;

  // register writes always taken
  assign cfg_ready_o = 1'b1;

  plc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plc_dp #(
    .COUNT_BITS(COUNT_BITS),
    .TALLY_BITS(TALLY_BITS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_we_i            (cfg_valid_i && cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .position_i          (position_i),
    .depth_i             (depth_i),
    .count_a_i           (count_a_i),
    .count_c_i           (count_c_i),
    .count_g_i           (count_g_i),
    .count_t_i           (count_t_i),
    .count_nonref_i      (count_nonref_i),
    .last_locus_i        (last_locus_i),
    .out_stall_i         (out_stall_i),
    .out_valid_o         (out_valid_o),
    .multiallelic_loci_o (multiallelic_loci_o),
    .unbalanced_loci_o   (unbalanced_loci_o),
    .flank_loci_o        (flank_loci_o),
    .nonref_flank_loci_o (nonref_flank_loci_o),
    .nonref_fraction_o   (nonref_fraction_o),
    .no_flank_loci_o     (no_flank_loci_o)
  );

  // one item at a time: an accepted item blocks the input next cycle
  `PLC_ASSERT_NEXT(a_one_item, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o, "input not blocked after accept")
  // a loaded result shows up as valid
  `PLC_ASSERT_NEXT(a_load_valid, clk_i, rst_ni, cmd.load, out_valid_o, "loaded result not valid")
  // no flank loci always reports a zero fraction
  `PLC_ASSERT_NOW(a_no_flank_zero, clk_i, rst_ni, out_valid_o && no_flank_loci_o, nonref_fraction_o == '0, "fraction set with no flank loci")

endmodule

@@ test/tb_pileup_locus_statistics_core.sv @@
// self-checking testbench for pileup_locus_statistics_core: tallies loci per region and
// compares each emitted statistics item against a cycle-free prediction
// depends on plc_pkg and the core's rtl only
`timescale 1ns / 1ps

module tb_pileup_locus_statistics_core;
  import plc_pkg::*;

  localparam int unsigned CNT_W = DEF_COUNT_BITS;
  localparam int CYCLE_LIMIT    = 250000;
  localparam int SETTLE_CYCLES  = 48;
  localparam int LONG_HOLD      = 400;
  localparam int MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNLISTED = 3'd5;
  localparam int NUM_UNLISTED   = 3;

  typedef struct {
    logic [POS_W-1:0]   position;
    logic [DEPTH_W-1:0] depth;
    logic [CNT_W-1:0]   count_a;
    logic [CNT_W-1:0]   count_c;
    logic [CNT_W-1:0]   count_g;
    logic [CNT_W-1:0]   count_t;
    logic [CNT_W-1:0]   count_nonref;
    logic               last_locus;
  } locus_t;

  typedef struct packed {
    logic [OUT_W-1:0]  multiallelic;
    logic [OUT_W-1:0]  unbalanced;
    logic [OUT_W-1:0]  flank;
    logic [OUT_W-1:0]  nonref;
    logic [FRAC_W-1:0] fraction;
    logic              no_flank;
  } locus_stats_t;

  // running tallies of the region, expected statistics in arrival order
  class locus_tally_model;
    logic [POS_W-1:0]   feature_start;
    logic [POS_W-1:0]   feature_end;
    logic               use_reference;
    logic [DEPTH_W-1:0] min_allelic_depth;
    logic [DEPTH_W-1:0] min_flank_depth;
    logic [OUT_W-1:0]   multi_cnt;
    logic [OUT_W-1:0]   unbal_cnt;
    logic [OUT_W-1:0]   flank_cnt;
    logic [OUT_W-1:0]   nonref_cnt;
    locus_stats_t       expected_stats [$];
    int                 mismatches;

    function new();
      feature_start     = '0;
      feature_end       = '0;
      use_reference     = 1'b0;
      min_allelic_depth = RST_MIN_ALLELIC;
      min_flank_depth   = RST_MIN_FLANK;
      clear_tallies();
      mismatches = 0;
    endfunction

    function void clear_tallies();
      multi_cnt  = '0;
      unbal_cnt  = '0;
      flank_cnt  = '0;
      nonref_cnt = '0;
    endfunction

    function logic [OUT_W-1:0] bump(logic [OUT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // unlisted indexes fall through and change nothing
    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_FEATURE_START:   feature_start     = data;
        CFG_FEATURE_END:     feature_end       = data;
        CFG_USE_REFERENCE:   use_reference     = data[0];
        CFG_MIN_ALLELIC_DEP: min_allelic_depth = data[DEPTH_W-1:0];
        CFG_MIN_FLANK_DEP:   min_flank_depth   = data[DEPTH_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction

    // classify one accepted locus; on the last one queue the statistics
    function void note_locus(locus_t it);
      logic [63:0]  d, nref, mx, second, total, frac;
      logic [63:0]  c [4];
      int           top;
      logic         in_feature, multi;
      locus_stats_t st;
      d          = 64'(it.depth);
      nref       = 64'(it.count_nonref);
      c[0]       = 64'(it.count_a);
      c[1]       = 64'(it.count_c);
      c[2]       = 64'(it.count_g);
      c[3]       = 64'(it.count_t);
      in_feature = (it.position > feature_start) && (it.position < feature_end);
      if (in_feature) begin
        if (it.depth >= min_allelic_depth && d != 0) begin
          multi = 1'b1;
          for (int k = 0; k < 4; k++) begin
            if (5 * c[k] >= 4 * d) multi = 1'b0;
          end
          if (multi) begin
            multi_cnt = bump(multi_cnt);
            // first maximum wins a tie; second is the largest of the rest
            mx  = c[0];
            top = 0;
            for (int k = 1; k < 4; k++) begin
              if (c[k] > mx) begin
                mx  = c[k];
                top = k;
              end
            end
            second = 0;
            for (int k = 0; k < 4; k++) begin
              if (k != top && c[k] > second) second = c[k];
            end
            total = mx + second;
            if (total > 0 && 5 * second > total && 10 * second < 3 * total)
              unbal_cnt = bump(unbal_cnt);
          end
        end
      end else if (it.depth >= min_flank_depth) begin
        flank_cnt = bump(flank_cnt);
        if (use_reference && d != 0 && 200 * nref >= d) nonref_cnt = bump(nonref_cnt);
      end
      if (!it.last_locus) return;
      frac = 0;
      if (flank_cnt != 0 && use_reference) begin
        frac = ({32'b0, nonref_cnt} << 16) / flank_cnt;
        if (frac > 65536) frac = 65536;
      end
      st.multiallelic = multi_cnt;
      st.unbalanced   = unbal_cnt;
      st.flank        = flank_cnt;
      st.nonref       = nonref_cnt;
      st.fraction     = frac[FRAC_W-1:0];
      st.no_flank     = (flank_cnt == 0);
      expected_stats  = {expected_stats, st};
      clear_tallies();
    endfunction

    function void flag(string what, locus_stats_t want, locus_stats_t got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t %s: exp multi=%0d unbal=%0d flank=%0d nonref=%0d frac=%0d none=%0b | got multi=%0d unbal=%0d flank=%0d nonref=%0d frac=%0d none=%0b",
                 $time, what, want.multiallelic, want.unbalanced, want.flank, want.nonref,
                 want.fraction, want.no_flank, got.multiallelic, got.unbalanced, got.flank,
                 got.nonref, got.fraction, got.no_flank);
    endfunction

    function void check_stats(locus_stats_t got);
      locus_stats_t want;
      if (expected_stats.size() == 0) begin
        flag("unexpected stats item", '0, got);
        return;
      end
      want = expected_stats.pop_front();
      if (got !== want) flag("stats mismatch", want, got);
    endfunction

    function void flush_leftover();
      while (expected_stats.size() != 0)
        flag("stats item never arrived", expected_stats.pop_front(), '0);
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [POS_W-1:0]      position_i;
  logic [DEPTH_W-1:0]    depth_i;
  logic [CNT_W-1:0]      count_a_i;
  logic [CNT_W-1:0]      count_c_i;
  logic [CNT_W-1:0]      count_g_i;
  logic [CNT_W-1:0]      count_t_i;
  logic [CNT_W-1:0]      count_nonref_i;
  logic                  last_locus_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [OUT_W-1:0]      multiallelic_loci_o;
  logic [OUT_W-1:0]      unbalanced_loci_o;
  logic [OUT_W-1:0]      flank_loci_o;
  logic [OUT_W-1:0]      nonref_flank_loci_o;
  logic [FRAC_W-1:0]     nonref_fraction_o;
  logic                  no_flank_loci_o;

  locus_tally_model tally;
  int   cycle_count  = 0;
  int   burst_left   = 0;
  bit   no_gaps      = 1'b0;
  bit   hold_request = 1'b0;
  int   hold_left    = 0;
  int   stall_mode   = 0;
  int   mode_left    = 0;
  int   stall_period = 2;
  int   stall_phase  = 0;

  pileup_locus_statistics_core u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .position_i          (position_i),
    .depth_i             (depth_i),
    .count_a_i           (count_a_i),
    .count_c_i           (count_c_i),
    .count_g_i           (count_g_i),
    .count_t_i           (count_t_i),
    .count_nonref_i      (count_nonref_i),
    .last_locus_i        (last_locus_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .multiallelic_loci_o (multiallelic_loci_o),
    .unbalanced_loci_o   (unbalanced_loci_o),
    .flank_loci_o        (flank_loci_o),
    .nonref_flank_loci_o (nonref_flank_loci_o),
    .nonref_fraction_o   (nonref_fraction_o),
    .no_flank_loci_o     (no_flank_loci_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // check every accepted statistics item
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      tally.check_stats(locus_stats_t'({multiallelic_loci_o, unbalanced_loci_o, flank_loci_o,
                                        nonref_flank_loci_o, nonref_fraction_o,
                                        no_flank_loci_o}));
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_left    = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          stall_mode   = $urandom_range(0, 3);
          mode_left    = $urandom_range(20, 120);
          stall_period = $urandom_range(2, 9);
        end
        mode_left--;
        stall_phase++;
        case (stall_mode)
          0:       out_stall_i <= 1'b0;
          1:       out_stall_i <= ($urandom_range(0, 9) < 3);
          2:       out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= ((stall_phase % stall_period) < (stall_period / 2));
        endcase
      end
    end
  end

  function automatic locus_t mk(logic [POS_W-1:0] pos, logic [DEPTH_W-1:0] d,
                                logic [CNT_W-1:0] a, logic [CNT_W-1:0] c,
                                logic [CNT_W-1:0] g, logic [CNT_W-1:0] t,
                                logic [CNT_W-1:0] nr, logic last);
    locus_t it;
    it.position     = pos;
    it.depth        = d;
    it.count_a      = a;
    it.count_c      = c;
    it.count_g      = g;
    it.count_t      = t;
    it.count_nonref = nr;
    it.last_locus   = last;
    return it;
  endfunction

  // positions biased to the feature interior and its bounds
  function automatic logic [POS_W-1:0] pick_position();
    logic [63:0] fs, fe;
    fs = 64'(tally.feature_start);
    fe = 64'(tally.feature_end);
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        if (fe > fs + 1) return $urandom_range(32'(fe - 1), 32'(fs + 1));
        return $urandom;
      end
      4:       return 32'(fs);
      5:       return 32'(fe);
      6:       return 32'(fs + 1);
      7:       return 32'(fe - 1);
      8:       return $urandom;
      default: return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  // depths near the thresholds, small, extreme or random
  function automatic logic [DEPTH_W-1:0] pick_depth();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return 16'($urandom_range(0, 300));
      5:             return tally.min_allelic_depth - 16'($urandom_range(0, 1));
      6:             return tally.min_flank_depth - 16'($urandom_range(0, 1));
      7:             return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default:       return 16'($urandom);
    endcase
  endfunction

  function automatic locus_t make_locus(logic last);
    locus_t      it;
    logic [63:0] d, s, second, rem, o1, o2, wsum;
    logic [63:0] cnt [4];
    logic [63:0] tmp;
    int unsigned w [4];
    int          j;
    it.position = pick_position();
    it.depth    = pick_depth();
    d           = 64'(it.depth);
    case ($urandom_range(0, 9))
      // random split of the depth
      0, 1, 2: begin
        wsum = 0;
        for (int k = 0; k < 4; k++) begin
          w[k] = $urandom_range(0, 255);
          wsum += w[k];
        end
        for (int k = 0; k < 4; k++) cnt[k] = (wsum == 0) ? 0 : d * w[k] / wsum;
      end
      // two leading bases with a minor share near the unbalanced window
      3, 4: begin
        s      = d * $urandom_range(60, 95) / 100;
        second = s * $urandom_range(17, 33) / 100;
        rem    = d - s;
        o1     = 64'($urandom_range(0, 32'(rem)));
        cnt[0] = s - second;
        cnt[1] = second;
        cnt[2] = o1;
        cnt[3] = rem - o1;
      end
      // one dominant base
      5: begin
        cnt[0] = d * $urandom_range(78, 100) / 100;
        rem    = d - cnt[0];
        o1     = 64'($urandom_range(0, 32'(rem)));
        o2     = 64'($urandom_range(0, 32'(rem - o1)));
        cnt[1] = o1;
        cnt[2] = o2;
        cnt[3] = rem - o1 - o2;
      end
      // tied counts
      6: begin
        tmp    = d / $urandom_range(2, 4);
        cnt[0] = tmp;
        cnt[1] = tmp;
        cnt[2] = $urandom_range(0, 1) ? tmp : 64'($urandom_range(0, 32'(tmp)));
        cnt[3] = 64'($urandom_range(0, 32'(tmp)));
      end
      // counts unrelated to depth
      7, 8: for (int k = 0; k < 4; k++) cnt[k] = 64'($urandom_range(0, 65535));
      default: for (int k = 0; k < 4; k++) cnt[k] = 64'($urandom_range(0, 3));
    endcase
    for (int k = 3; k > 0; k--) begin
      j      = $urandom_range(0, k);
      tmp    = cnt[k];
      cnt[k] = cnt[j];
      cnt[j] = tmp;
    end
    it.count_a = cnt[0][CNT_W-1:0];
    it.count_c = cnt[1][CNT_W-1:0];
    it.count_g = cnt[2][CNT_W-1:0];
    it.count_t = cnt[3][CNT_W-1:0];
    case ($urandom_range(0, 5))
      0:       it.count_nonref = '0;
      1, 2, 3: it.count_nonref = 16'($urandom_range(0, 32'(d / 100 + 2)));
      4:       it.count_nonref = $urandom_range(0, 1) ? 16'(d / 200) : 16'((d + 199) / 200);
      default: it.count_nonref = 16'($urandom);
    endcase
    it.last_locus = last;
    return it;
  endfunction

  function automatic locus_t noise_locus();
    return mk($urandom, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), 16'($urandom), 1'($urandom));
  endfunction

  // offer one locus in bursts with random gaps, hold it until accepted
  task automatic send_locus(locus_t it);
    int gap;
    if (burst_left == 0) begin
      gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    position_i     <= it.position;
    depth_i        <= it.depth;
    count_a_i      <= it.count_a;
    count_c_i      <= it.count_c;
    count_g_i      <= it.count_g;
    count_t_i      <= it.count_t;
    count_nonref_i <= it.count_nonref;
    last_locus_i   <= it.last_locus;
    do @(posedge clk_i); while (in_stall_o);
    tally.note_locus(it);
  endtask

  // stop offering and let every queued statistics item drain
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (tally.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tally.set_register(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic configure(logic [31:0] fs, logic [31:0] fe, logic [31:0] ref_bits,
                           logic [31:0] min_a, logic [31:0] min_f);
    wait_drained();
    write_register(CFG_FEATURE_START, fs);
    write_register(CFG_FEATURE_END, fe);
    write_register(CFG_USE_REFERENCE, ref_bits);
    write_register(CFG_MIN_ALLELIC_DEP, min_a);
    write_register(CFG_MIN_FLANK_DEP, min_f);
  endtask

  // regions of random length, each closed by a last locus, with some noise mixed in
  task automatic send_regions(int n_items, int max_region);
    int remaining, len;
    remaining = n_items;
    while (remaining > 0) begin
      len = $urandom_range(1, max_region);
      if (len > remaining) len = remaining;
      for (int i = 0; i < len; i++) begin
        if (i != len - 1 && $urandom_range(0, 9) == 0) send_locus(noise_locus());
        else send_locus(make_locus(i == len - 1));
      end
      remaining -= len;
    end
  endtask

  initial begin
    tally          = new();
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    position_i     = '0;
    depth_i        = '0;
    count_a_i      = '0;
    count_c_i      = '0;
    count_g_i      = '0;
    count_t_i      = '0;
    count_nonref_i = '0;
    last_locus_i   = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset defaults: empty feature, reference use off
    send_locus(mk(32'd0, 16'd10, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_locus(mk('1, 16'd9, 16'd9, 16'd0, 16'd0, 16'd0, 16'd9, 1'b0));
    send_locus(mk(32'd1500, '1, '1, '1, '1, '1, '1, 1'b1));

    // feature interior only, so no flank loci
    configure(32'd1000, 32'd2000, 32'd1, 32'd12, 32'd10);
    send_locus(mk(32'd1500, 16'd100, 16'd25, 16'd25, 16'd25, 16'd25, 16'd0, 1'b0));
    send_locus(mk(32'd1001, 16'd100, 16'd70, 16'd25, 16'd5, 16'd0, 16'd0, 1'b0));
    send_locus(mk(32'd1999, 16'd100, 16'd80, 16'd10, 16'd5, 16'd5, 16'd0, 1'b0));
    // tie for the maximum, first or later base
    send_locus(mk(32'd1500, 16'd100, 16'd40, 16'd40, 16'd10, 16'd10, 16'd0, 1'b0));
    send_locus(mk(32'd1500, 16'd100, 16'd10, 16'd40, 16'd40, 16'd10, 16'd0, 1'b0));
    // minor share exactly at the lower and the upper bound
    send_locus(mk(32'd1500, 16'd100, 16'd60, 16'd15, 16'd15, 16'd10, 16'd0, 1'b0));
    send_locus(mk(32'd1500, 16'd100, 16'd49, 16'd21, 16'd20, 16'd10, 16'd0, 1'b0));
    send_locus(mk(32'd1500, 16'd11, 16'd3, 16'd3, 16'd3, 16'd2, 16'd0, 1'b1));
    // flank loci on the bounds and beyond, nonref fraction at its edge
    send_locus(mk(32'd1000, 16'd200, 16'd150, 16'd50, 16'd0, 16'd0, 16'd1, 1'b0));
    send_locus(mk(32'd2000, 16'd201, 16'd150, 16'd51, 16'd0, 16'd0, 16'd1, 1'b0));
    send_locus(mk(32'd0, 16'd10, 16'd10, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_locus(mk('1, 16'd9, 16'd9, 16'd0, 16'd0, 16'd0, 16'd9, 1'b0));
    send_locus(mk(32'd5, '1, '1, '1, '1, '1, '1, 1'b0));
    send_locus(mk(32'd1500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));
    // zero depth passes a zero flank minimum but not the allelic check, counts above depth, all-zero counts
    configure(32'd1000, 32'd2000, 32'd1, 32'd0, 32'd0);
    send_locus(mk(32'd10, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd5, 1'b0));
    send_locus(mk(32'd1500, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0));
    send_locus(mk(32'd1500, 16'd10, 16'd100, 16'd100, 16'd100, 16'd100, 16'd0, 1'b0));
    send_locus(mk(32'd1500, 16'd50, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1));

    // random phases across several register settings
    configure(32'd1000, 32'd2000, 32'd1, 32'd12, 32'd10);
    send_regions(70, 12);
    configure(32'd0, '1, 32'd1, 32'd0, 32'd0);
    send_regions(70, 12);
    configure(32'd5000, 32'd5001, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'h0000_FFFF);
    send_regions(50, 12);
    configure($urandom_range(0, 100000), $urandom_range(0, 200000), $urandom,
              {16'($urandom), 16'($urandom_range(0, 40))},
              {16'($urandom), 16'($urandom_range(0, 40))});
    for (int k = 0; k < NUM_UNLISTED; k++)
      write_register(CFG_IDX_W'(CFG_FIRST_UNLISTED + k), $urandom);
    send_regions(70, 12);

    // long receiver hold-off while loci keep coming, filling the block
    configure(32'd100, 32'd900, 32'd1, 32'd12, 32'd10);
    no_gaps      = 1'b1;
    hold_request = 1'b1;
    send_regions(40, 3);
    no_gaps = 1'b0;

    configure('1, 32'd0, 32'd1, 32'd1, 32'd1);
    send_regions(50, 12);
    configure($urandom, $urandom, $urandom, 32'($urandom_range(0, 64)),
              32'($urandom_range(0, 64)));
    send_regions(60, 12);

    wait_drained();
    tally.flush_leftover();
    if (tally.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/plc_pkg.sv
hdl/plc_div.sv
hdl/plc_dp.sv
hdl/plc_ctrl.sv
hdl/pileup_locus_statistics_core.sv
test/tb_pileup_locus_statistics_core.sv
